### sv/bptc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Widths, calibration register indexes and reset values shared by the
// interfaces and the compensation core.
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int RAW_W     = 24;
	localparam int COEF_W    = 16;
	localparam int TEMP_W    = 19;
	localparam int PRES_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Calibration register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESSURE_SENS  = 3'd0,
		REG_PRESSURE_OFFSET = 3'd1,
		REG_SENS_TEMP      = 3'd2,
		REG_OFFSET_TEMP    = 3'd3,
		REG_REFERENCE_TEMP = 3'd4,
		REG_TEMP_SLOPE     = 3'd5
	} cfg_reg_t;

	localparam logic [COEF_W-1:0] RST_PRESSURE_SENS   = 16'd40127;
	localparam logic [COEF_W-1:0] RST_PRESSURE_OFFSET = 16'd36924;
	localparam logic [COEF_W-1:0] RST_SENS_TEMP       = 16'd23317;
	localparam logic [COEF_W-1:0] RST_OFFSET_TEMP     = 16'd23282;
	localparam logic [COEF_W-1:0] RST_REFERENCE_TEMP  = 16'd33464;
	localparam logic [COEF_W-1:0] RST_TEMP_SLOPE      = 16'd28312;

	// Reference temperature in hundredths of a degree.
	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

endpackage

### sv/bptc_if.sv
// ----------------------------------------------------------------------------
// Barometric compensation channels
// Valid/ready channels for raw samples, compensated results and calibration
// register writes.
// ----------------------------------------------------------------------------
interface bptc_sample_if;
	import bptc_pkg::*;
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  raw_pressure;
	logic [RAW_W-1:0]  raw_temperature;

	modport source (output valid, raw_pressure, raw_temperature, input ready);
	modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bptc_result_if;
	import bptc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [TEMP_W-1:0]  temperature;
	logic signed [PRES_W-1:0]  pressure;
	logic                      pressure_valid;

	modport source (output valid, temperature, pressure, pressure_valid, input ready);
	modport sink   (input valid, temperature, pressure, pressure_valid, output ready);
endinterface

interface bptc_cfg_if;
	import bptc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [COEF_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### sv/baro_pressure_temp_compensation_core.sv
// ----------------------------------------------------------------------------
// Barometric pressure and temperature compensation core
// Turns raw 24-bit pressure and temperature conversions into a compensated
// temperature and pressure, with second-order correction below 20.00 degrees.
// ----------------------------------------------------------------------------
// The core takes one sample word per clock unless a result channel stall has
// filled every stage, and returns one result word for each sample, in order.
// The datapath has ten stages, among them the first-order products, the
// second-order square, and the wide pressure product, which is split into two
// 24x19 partial products recombined in the following stage. Back-pressure
// propagates stage by stage, so empty stages fill while the result channel
// stalls. Calibration registers are written through the configuration
// channel, which is always ready; writes to indexes above five are dropped,
// and writes are meant to happen only while the core is empty.
module baro_pressure_temp_compensation_core (
	input  logic                   clk,
	input  logic                   arst_n,
	bptc_sample_if.sink            sample,
	bptc_result_if.source          result,
	bptc_cfg_if.sink               cfg
);
	import bptc_pkg::*;

	localparam int STAGES = 10;

	// Calibration registers.
	logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= RST_PRESSURE_SENS;
			c2_q <= RST_PRESSURE_OFFSET;
			c3_q <= RST_SENS_TEMP;
			c4_q <= RST_OFFSET_TEMP;
			c5_q <= RST_REFERENCE_TEMP;
			c6_q <= RST_TEMP_SLOPE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PRESSURE_SENS:   c1_q <= cfg.data;
				REG_PRESSURE_OFFSET: c2_q <= cfg.data;
				REG_SENS_TEMP:       c3_q <= cfg.data;
				REG_OFFSET_TEMP:     c4_q <= cfg.data;
				REG_REFERENCE_TEMP:  c5_q <= cfg.data;
				REG_TEMP_SLOPE:      c6_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pipeline control: a stage loads when it is empty or its word moves on.
	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] en;

	always_comb begin
		en[STAGES+1] = result.ready;
		for (int k = STAGES; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign sample.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= sample.valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: temperature difference from the reference.
	logic signed [24:0]  dt_d;
	logic [RAW_W-1:0]    d1_s1;
	logic signed [24:0]  dt_s1;
	logic                pv_s1;

	assign dt_d = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5_q, 8'd0});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s1 <= sample.raw_pressure;
			dt_s1 <= dt_d;
			pv_s1 <= (sample.raw_pressure != '0);
		end
	end

	// Stage 2: first-order products.
	logic signed [41:0]  p6_s2, p4_s2, p3_s2;
	logic signed [49:0]  pdd_s2;
	logic [RAW_W-1:0]    d1_s2;
	logic                pv_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p6_s2  <= dt_s1 * $signed({1'b0, c6_q});
			p4_s2  <= dt_s1 * $signed({1'b0, c4_q});
			p3_s2  <= dt_s1 * $signed({1'b0, c3_q});
			pdd_s2 <= dt_s1 * dt_s1;
			d1_s2  <= d1_s1;
			pv_s2  <= pv_s1;
		end
	end

	// Stage 3: truncating scale-downs, first-order temperature, offset, sensitivity.
	logic signed [41:0]  p6_b, p4_b, p3_b;
	logic signed [17:0]  q6_d;
	logic signed [34:0]  off_t_d;
	logic signed [33:0]  sens_t_d;

	assign p6_b     = p6_s2 + (p6_s2[41] ? 42'sd8388607 : 42'sd0);
	assign p4_b     = p4_s2 + (p4_s2[41] ? 42'sd127 : 42'sd0);
	assign p3_b     = p3_s2 + (p3_s2[41] ? 42'sd255 : 42'sd0);
	assign q6_d     = p6_b[40:23];
	assign off_t_d  = p4_b[41:7];
	assign sens_t_d = p3_b[41:8];

	logic signed [17:0]       q6_s3;
	logic signed [TEMP_W-1:0] temp1_s3;
	logic signed [34:0]       off1_s3, sens1_s3;
	logic [16:0]              t2_s3;
	logic [RAW_W-1:0]         d1_s3;
	logic                     pv_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q6_s3    <= q6_d;
			temp1_s3 <= TEMP_REF + {q6_d[17], q6_d};
			off1_s3  <= $signed({3'd0, c2_q, 16'd0}) + off_t_d;
			sens1_s3 <= $signed({4'd0, c1_q, 15'd0}) + {sens_t_d[33], sens_t_d};
			t2_s3    <= pdd_s2[47:31];
			d1_s3    <= d1_s2;
			pv_s3    <= pv_s2;
		end
	end

	// Stage 4: square of the deviation below the reference.
	logic signed [35:0]       sq_d;
	logic [33:0]              sq_s4;
	logic                     low_s4;
	logic signed [TEMP_W-1:0] temp1_s4;
	logic signed [34:0]       off1_s4, sens1_s4;
	logic [16:0]              t2_s4;
	logic [RAW_W-1:0]         d1_s4;
	logic                     pv_s4;

	assign sq_d = q6_s3 * q6_s3;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sq_s4    <= sq_d[33:0];
			// Second-order terms apply only to a good read below the reference.
			low_s4   <= q6_s3[17] && pv_s3;
			temp1_s4 <= temp1_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			t2_s4    <= t2_s3;
			d1_s4    <= d1_s3;
			pv_s4    <= pv_s3;
		end
	end

	// Stage 5: second-order corrections.
	logic [36:0]              sq5_d;
	logic [35:0]              off2_d;
	logic [34:0]              sens2_d;
	logic signed [TEMP_W-1:0] temp_s5;
	logic signed [37:0]       off_s5, sens_s5;
	logic [RAW_W-1:0]         d1_s5;
	logic                     pv_s5;

	assign sq5_d   = {3'd0, sq_s4} + {1'b0, sq_s4, 2'd0};
	assign off2_d  = sq5_d[36:1];
	assign sens2_d = sq5_d[36:2];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			temp_s5 <= temp1_s4 - (low_s4 ? $signed({2'd0, t2_s4}) : 19'sd0);
			off_s5  <= {{3{off1_s4[34]}}, off1_s4}
				- (low_s4 ? $signed({2'd0, off2_d}) : 38'sd0);
			sens_s5 <= {{3{sens1_s4[34]}}, sens1_s4}
				- (low_s4 ? $signed({3'd0, sens2_d}) : 38'sd0);
			d1_s5   <= d1_s4;
			pv_s5   <= pv_s4;
		end
	end

	// Stage 6: raw pressure times sensitivity as two partial products.
	logic [42:0]              plo_s6;
	logic signed [43:0]       phi_s6;
	logic signed [37:0]       off_s6;
	logic signed [TEMP_W-1:0] temp_s6;
	logic                     pv_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			plo_s6  <= d1_s5 * sens_s5[18:0];
			phi_s6  <= $signed({1'b0, d1_s5}) * $signed(sens_s5[37:19]);
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
			pv_s6   <= pv_s5;
		end
	end

	// Stage 7: recombine the partial products.
	logic signed [61:0]       prod_s7;
	logic signed [37:0]       off_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	logic                     pv_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			prod_s7 <= $signed({phi_s6[42:0], 19'd0}) + $signed({19'd0, plo_s6});
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
			pv_s7   <= pv_s6;
		end
	end

	// Stage 8: scale the product down, truncating toward zero.
	logic signed [61:0]       prod_b;
	logic signed [40:0]       q1_s8;
	logic signed [37:0]       off_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	logic                     pv_s8;

	assign prod_b = prod_s7 + (prod_s7[61] ? 62'sd2097151 : 62'sd0);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			q1_s8   <= prod_b[61:21];
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
			pv_s8   <= pv_s7;
		end
	end

	// Stage 9: subtract the offset.
	logic signed [41:0]       diff_s9;
	logic signed [TEMP_W-1:0] temp_s9;
	logic                     pv_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			diff_s9 <= {q1_s8[40], q1_s8} - {{4{off_s8[37]}}, off_s8};
			temp_s9 <= temp_s8;
			pv_s9   <= pv_s8;
		end
	end

	// Stage 10: final scale-down into the output register.
	logic signed [41:0]       diff_b;
	logic signed [26:0]       pq_d;
	logic signed [PRES_W-1:0] pres_s10;
	logic signed [TEMP_W-1:0] temp_s10;
	logic                     pv_s10;

	assign diff_b = diff_s9 + (diff_s9[41] ? 42'sd32767 : 42'sd0);
	assign pq_d   = diff_b[41:15];

	always_ff @(posedge clk) begin
		if (en[10]) begin
			pres_s10 <= pv_s9 ? {{5{pq_d[26]}}, pq_d} : '0;
			temp_s10 <= temp_s9;
			pv_s10   <= pv_s9;
		end
	end

	assign result.valid          = vld_q[STAGES];
	assign result.temperature    = temp_s10;
	assign result.pressure       = pres_s10;
	assign result.pressure_valid = pv_s10;

	// A failed read never carries a pressure.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.pressure_valid |-> result.pressure == '0)
		else $error("failed-read word carries a nonzero pressure");

	// Without the second-order path the first-order temperature passes unchanged.
	a_first_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] && en[5] && !low_s4 |=> temp_s5 == $past(temp1_s4))
		else $error("first-order temperature altered without correction");

	// The input side only stalls when every stage holds a word.
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> vld_q == '1)
		else $error("input stalled while a stage is empty");

endmodule

### verif/baro_compensation_checker.sv
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Watches the sample, result and calibration channels of the compensation
// core. It keeps its own copy of the calibration words, predicts the
// compensated temperature and pressure for every accepted sample word, and
// compares each result word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module baro_compensation_checker (
	input  logic   clk,
	input  logic   arst_n,
	bptc_sample_if sample,
	bptc_result_if result,
	bptc_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);
	import bptc_pkg::*;

	localparam longint TEMP_REF_WIDE = longint'(TEMP_REF);
	localparam longint TWO_POW_31    = 64'sd2147483648;
	localparam int     PRINT_CAP     = 40;

	typedef struct {
		logic signed [TEMP_W-1:0] temperature;
		logic signed [PRES_W-1:0] pressure;
		logic                     pressure_valid;
	} compensated_t;

	logic [COEF_W-1:0] sens_coef;
	logic [COEF_W-1:0] offset_coef;
	logic [COEF_W-1:0] sens_tc_coef;
	logic [COEF_W-1:0] offset_tc_coef;
	logic [COEF_W-1:0] ref_temp_coef;
	logic [COEF_W-1:0] temp_slope_coef;

	compensated_t compensated_q [$];
	int           mismatch_count = 0;
	int           result_index = 0;

	assign mismatches  = mismatch_count;
	assign outstanding = compensated_q.size();

	task automatic report(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] compensation check, result %0d: %s", $time, result_index, msg);
		mismatch_count++;
	endtask

	// All quotients truncate toward zero, as SystemVerilog signed division does.
	function automatic compensated_t compensate(input logic [RAW_W-1:0] raw_p,
			input logic [RAW_W-1:0] raw_t);
		compensated_t r;
		longint d1, dt, temp, off, sens, dev, sq, pres;
		d1   = longint'(raw_p);
		dt   = longint'(raw_t) - longint'(ref_temp_coef) * 256;
		temp = TEMP_REF_WIDE + dt * longint'(temp_slope_coef) / 8388608;
		pres = 0;
		r.pressure_valid = 1'b0;
		if (raw_p != '0) begin
			off  = longint'(offset_coef) * 65536 + longint'(offset_tc_coef) * dt / 128;
			sens = longint'(sens_coef) * 32768 + longint'(sens_tc_coef) * dt / 256;
			// Cold branch: second-order terms from the exact squared deviation.
			if (temp < TEMP_REF_WIDE) begin
				dev  = temp - TEMP_REF_WIDE;
				sq   = dev * dev;
				temp = temp - dt * dt / TWO_POW_31;
				off  = off - 5 * sq / 2;
				sens = sens - 5 * sq / 4;
			end
			pres = (d1 * sens / 2097152 - off) / 32768;
			r.pressure_valid = 1'b1;
		end
		r.temperature = temp[TEMP_W-1:0];
		r.pressure    = pres[PRES_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		compensated_t want;
		if (!arst_n) begin
			sens_coef       <= RST_PRESSURE_SENS;
			offset_coef     <= RST_PRESSURE_OFFSET;
			sens_tc_coef    <= RST_SENS_TEMP;
			offset_tc_coef  <= RST_OFFSET_TEMP;
			ref_temp_coef   <= RST_REFERENCE_TEMP;
			temp_slope_coef <= RST_TEMP_SLOPE;
		end else begin
			if (result.valid && result.ready) begin
				if (compensated_q.size() == 0) begin
					report($sformatf("unexpected word, temperature %0d pressure %0d",
						result.temperature, result.pressure));
				end else begin
					want = compensated_q.pop_front();
					if (result.temperature !== want.temperature)
						report($sformatf("temperature %0d, expected %0d",
							result.temperature, want.temperature));
					if (result.pressure !== want.pressure)
						report($sformatf("pressure %0d, expected %0d",
							result.pressure, want.pressure));
					if (result.pressure_valid !== want.pressure_valid)
						report($sformatf("pressure_valid %b, expected %b",
							result.pressure_valid, want.pressure_valid));
				end
				result_index++;
			end
			// Calibration updates land after this edge, so a sample taken on the
			// same edge still sees the old words, as the core's first stage does.
			if (sample.valid && sample.ready)
				compensated_q.push_back(compensate(sample.raw_pressure, sample.raw_temperature));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PRESSURE_SENS:   sens_coef       <= cfg.data;
					REG_PRESSURE_OFFSET: offset_coef     <= cfg.data;
					REG_SENS_TEMP:       sens_tc_coef    <= cfg.data;
					REG_OFFSET_TEMP:     offset_tc_coef  <= cfg.data;
					REG_REFERENCE_TEMP:  ref_temp_coef   <= cfg.data;
					REG_TEMP_SLOPE:      temp_slope_coef <= cfg.data;
					default: ;
				endcase
			end
		end
	end

endmodule

### verif/baro_pressure_temp_compensation_core_test.sv
// ----------------------------------------------------------------------------
// Barometric compensation core testbench
// Drives raw sample words and calibration writes into the compensation core
// under random idling on both channels, runs several calibration settings
// including all-zero and all-one words, and leaves the checking to the
// checker instantiated beside the core.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core_test;
	import bptc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;
	localparam logic [RAW_W-1:0]     RAW_MAX         = 24'hFFFFFF;
	localparam int                   IDLE_PCT        = 20;
	localparam int                   LATENCY_SLACK   = 16;
	localparam int                   STALL_LIMIT     = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   mismatches;
	int   outstanding;
	int   stall_cycles = 0;

	logic [COEF_W-1:0] coef_shadow [6];

	bptc_sample_if sample();
	bptc_result_if result();
	bptc_cfg_if    cfg();

	baro_pressure_temp_compensation_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	baro_compensation_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.result      (result),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		result.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no word accepted for %0d cycles", stall_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Handshakes are sampled at the falling edge, where ready has settled.
	task automatic push_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
		bit took;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		sample.valid           <= 1'b1;
		sample.raw_pressure    <= p;
		sample.raw_temperature <= t;
		do begin
			@(negedge clk);
			took = sample.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		bit took;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do begin
			@(negedge clk);
			took = cfg.ready;
			@(posedge clk);
		end while (!took);
		cfg.valid <= 1'b0;
		if (idx <= REG_TEMP_SLOPE)
			coef_shadow[idx] = value;
		@(posedge clk);
	endtask

	task automatic set_all_coefs(input logic [COEF_W-1:0] fill, input bit scatter);
		for (int i = 0; i <= int'(REG_TEMP_SLOPE); i++)
			write_coef(CFG_IDX_W'(i), scatter ? COEF_W'($urandom()) : fill);
	endtask

	// The sender holds off until every predicted word has come back.
	task automatic drain_results();
		sample.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	// Temperatures cluster around the reference so both sides of the cold
	// threshold are hit often, with uniform words for the rest.
	task automatic random_samples(input int count);
		logic [RAW_W-1:0] p, t;
		int               pick, center, near;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 10)
				p = '0;
			else if (pick < 14)
				p = RAW_MAX;
			else if (pick < 17)
				p = 24'd1;
			else
				p = RAW_W'($urandom());
			pick   = $urandom_range(99);
			center = int'({coef_shadow[REG_REFERENCE_TEMP], 8'h00});
			if (pick < 45) begin
				t = RAW_W'($urandom());
			end else begin
				if (pick < 60)
					near = center + int'($urandom_range(1023)) - 512;
				else
					near = center + int'($urandom_range(131071)) - 65536;
				if (near < 0)
					near = 0;
				else if (near > int'(RAW_MAX))
					near = int'(RAW_MAX);
				t = near[RAW_W-1:0];
			end
			push_sample(p, t);
		end
	endtask

	initial begin
		logic [RAW_W-1:0] ref_raw;
		sample.valid           <= 1'b0;
		sample.raw_pressure    <= '0;
		sample.raw_temperature <= '0;
		cfg.valid              <= 1'b0;
		cfg.index              <= '0;
		cfg.data               <= '0;
		coef_shadow[REG_PRESSURE_SENS]   = RST_PRESSURE_SENS;
		coef_shadow[REG_PRESSURE_OFFSET] = RST_PRESSURE_OFFSET;
		coef_shadow[REG_SENS_TEMP]       = RST_SENS_TEMP;
		coef_shadow[REG_OFFSET_TEMP]     = RST_OFFSET_TEMP;
		coef_shadow[REG_REFERENCE_TEMP]  = RST_REFERENCE_TEMP;
		coef_shadow[REG_TEMP_SLOPE]      = RST_TEMP_SLOPE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: corners of the raw words, failed reads, and the
		// two raw temperatures on either side of the cold threshold.
		ref_raw = {coef_shadow[REG_REFERENCE_TEMP], 8'h00};
		push_sample(24'd0, ref_raw);
		push_sample(24'd0, 24'd0);
		push_sample(24'd0, RAW_MAX);
		push_sample(24'd1, ref_raw);
		push_sample(RAW_MAX, ref_raw);
		push_sample(RAW_MAX, 24'd0);
		push_sample(RAW_MAX, RAW_MAX);
		push_sample(24'd1, 24'd0);
		push_sample(24'd1, RAW_MAX);
		push_sample(24'd9085466, 24'd8569988);
		push_sample(24'd9085466, ref_raw - 24'd296);
		push_sample(24'd9085466, ref_raw - 24'd297);
		push_sample(24'd0, ref_raw - 24'd297);
		push_sample(24'hAAAAAA, 24'h555555);
		push_sample(24'h555555, 24'hAAAAAA);
		random_samples(160);
		drain_results();

		// All-one calibration words, no idling on either side.
		calm <= 1'b1;
		set_all_coefs('1, 1'b0);
		write_coef(IDX_UNMAPPED_LO, COEF_W'($urandom()));
		write_coef(IDX_UNMAPPED_HI, COEF_W'($urandom()));
		push_sample(RAW_MAX, 24'd0);
		push_sample(24'd1, RAW_MAX);
		push_sample(RAW_MAX, RAW_MAX);
		random_samples(140);
		drain_results();

		// All-zero calibration words.
		calm <= 1'b0;
		set_all_coefs('0, 1'b0);
		push_sample(RAW_MAX, RAW_MAX);
		push_sample(24'd0, 24'd0);
		random_samples(120);
		drain_results();

		for (int k = 0; k < 3; k++) begin
			set_all_coefs('0, 1'b1);
			random_samples(120);
			drain_results();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
